FILE: hdl/dtq_pkg.sv
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int ACTION_W  = 2;
    localparam int DELAY_W   = 16;
    localparam int TAG_W     = 8;
    localparam int PAYLOAD_W = 10;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 6;

    // command codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PURGE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [DELAY_W-1:0]   delay;
        logic [TAG_W-1:0]     tag;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [TAG_W-1:0]     out_tag;
        logic [DELAY_W-1:0]   out_delta;
        logic [CNT_OUT_W-1:0] removed;
        logic [CNT_OUT_W-1:0] occupancy;
    } rsp_t;

    // one stored list entry, link kept in a memory of its own
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [TAG_W-1:0]     tag;
        logic [DELAY_W-1:0]   delta;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_IALLOC,
        S_IWALK,
        S_ILINK,
        S_IFIX,
        S_PWALK,
        S_PEND,
        S_POP,
        S_RESP
    } state_t;

endpackage

FILE: hdl/delta_timer_queue.sv
`timescale 1ns / 1ps
// insert walks entries from the head until its place is found; purge walks every entry; pop reads the head
// full insert, empty purge, empty pop and no-op go straight to the result without touching the list
// one command at a time: cmd_ready is low from accept until its result is loaded into the output register
// reset: control registers, list head, free head, counts and fill counter clear at once
// entry memories are not cleared; the fill counter stands in for the initial free chain

module delta_timer_queue #(
    parameter int DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  dtq_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dtq_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(dtq_pkg::entry_t);
    localparam int DW = dtq_pkg::DELAY_W;
    localparam int OW = dtq_pkg::CNT_OUT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    // sequencer state
    dtq_pkg::state_t state_reg, state_next;

    // list bookkeeping (reset)
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] free_reg, free_next;
    logic [CW-1:0] count_reg, count_next;
    // slots at or above this mark were never allocated; their link is slot+1 (0 for the last slot)
    logic [CW-1:0] fresh_reg, fresh_next;

    // per-item working registers
    dtq_pkg::cmd_t   cmd_reg, cmd_next;
    logic [AW-1:0]   cur_reg, cur_next;
    logic [AW-1:0]   prev_reg, prev_next;
    logic            have_prev_reg, have_prev_next;
    logic [CW-1:0]   left_reg, left_next;
    logic [DW-1:0]   offset_reg, offset_next;
    logic [DW-1:0]   carry_reg, carry_next;
    logic            run_reg, run_next;
    dtq_pkg::entry_t ent_reg, ent_next;
    logic [AW-1:0]   slot_reg, slot_next;
    logic [dtq_pkg::STATUS_W-1:0] status_reg, status_next;
    dtq_pkg::entry_t pop_reg, pop_next;
    logic [CW-1:0]   removed_reg, removed_next;

    // output stage
    dtq_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // memory ports
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   link_q;
    dtq_pkg::entry_t data_q;
    logic            link_we;
    logic [AW-1:0]   link_waddr;
    logic [AW-1:0]   link_wdata;
    logic            data_we;
    logic [AW-1:0]   data_waddr;
    dtq_pkg::entry_t data_wdata;

    // link memory: list chain and free chain share it
    dtq_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (rd_addr),
        .rd_data (link_q)
    );

    // entry memory: payload, tag and relative delta
    dtq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (data_waddr),
        .wr_data (data_wdata),
        .rd_addr (rd_addr),
        .rd_data (data_q)
    );

    // decoded conditions
    logic          cnt_full;
    logic          cnt_empty;
    logic          fresh_hit;
    logic [AW-1:0] free_succ;
    logic          ins_adv;
    logic [CW-1:0] left_dec;
    logic          last_step;
    logic [DW-1:0] eff_delta;
    logic          tag_hit;
    logic [CW-1:0] purge_cnt;

    assign cnt_full  = (count_reg == FULL_CNT);
    assign cnt_empty = (count_reg == '0);
    // free head never written yet: follow the initial chain slot -> slot+1
    assign fresh_hit = (CW'(free_reg) >= fresh_reg);
    assign free_succ = (free_reg == LAST_SLOT) ? '0 : free_reg + AW'(1);
    // keep walking while the remaining offset covers this entry (fifo on ties)
    assign ins_adv   = (offset_reg >= data_q.delta);
    assign left_dec  = left_reg - CW'(1);
    assign last_step = (left_dec == '0);
    // delta of the current entry plus what removed predecessors handed down
    assign eff_delta = data_q.delta + carry_reg;
    assign tag_hit   = (data_q.tag == cmd_reg.tag);
    assign purge_cnt = count_reg - removed_reg;

    assign cmd_ready = (state_reg == dtq_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = dtq_pkg::S_START;
                end
            end
            dtq_pkg::S_START:
            begin
                case (cmd_reg.action)
                    dtq_pkg::ACT_INSERT:
                        state_next = cnt_full ? dtq_pkg::S_RESP : dtq_pkg::S_IALLOC;
                    dtq_pkg::ACT_PURGE:
                        state_next = cnt_empty ? dtq_pkg::S_RESP : dtq_pkg::S_PWALK;
                    dtq_pkg::ACT_POP:
                        state_next = cnt_empty ? dtq_pkg::S_RESP : dtq_pkg::S_POP;
                    default:
                        state_next = dtq_pkg::S_RESP;
                endcase
            end
            dtq_pkg::S_IALLOC:
                state_next = cnt_empty ? dtq_pkg::S_ILINK : dtq_pkg::S_IWALK;
            dtq_pkg::S_IWALK:
            begin
                if (!ins_adv || last_step)
                begin
                    state_next = dtq_pkg::S_ILINK;
                end
            end
            dtq_pkg::S_ILINK:
                state_next = dtq_pkg::S_IFIX;
            dtq_pkg::S_IFIX:
                state_next = dtq_pkg::S_RESP;
            dtq_pkg::S_PWALK:
            begin
                if (last_step)
                begin
                    state_next = dtq_pkg::S_PEND;
                end
            end
            dtq_pkg::S_PEND:
                state_next = dtq_pkg::S_RESP;
            dtq_pkg::S_POP:
                state_next = dtq_pkg::S_RESP;
            dtq_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = dtq_pkg::S_IDLE;
                end
            end
            default:
                state_next = dtq_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next      = head_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        left_next      = left_reg;
        offset_next    = offset_reg;
        carry_next     = carry_reg;
        run_next       = run_reg;
        ent_next       = ent_reg;
        slot_next      = slot_reg;
        status_next    = status_reg;
        pop_next       = pop_reg;
        removed_next   = removed_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        rd_addr    = cur_reg;
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = free_reg;
        data_we    = 1'b0;
        data_waddr = cur_reg;
        data_wdata = data_q;

        case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    status_next  = dtq_pkg::STAT_OK;
                    pop_next     = '0;
                    removed_next = '0;
                end
            end
            dtq_pkg::S_START:
            begin
                case (cmd_reg.action)
                    dtq_pkg::ACT_INSERT:
                    begin
                        if (cnt_full)
                        begin
                            status_next = dtq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // fetch the free slot's link to advance the free chain
                            rd_addr   = free_reg;
                            slot_next = free_reg;
                        end
                    end
                    dtq_pkg::ACT_PURGE:
                    begin
                        rd_addr        = head_reg;
                        cur_next       = head_reg;
                        left_next      = count_reg;
                        have_prev_next = 1'b0;
                        carry_next     = '0;
                        run_next       = 1'b0;
                    end
                    dtq_pkg::ACT_POP:
                    begin
                        if (cnt_empty)
                        begin
                            status_next = dtq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            rd_addr = head_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            dtq_pkg::S_IALLOC:
            begin
                free_next = fresh_hit ? free_succ : link_q;
                if (fresh_hit)
                begin
                    fresh_next = fresh_reg + CW'(1);
                end
                rd_addr        = head_reg;
                cur_next       = head_reg;
                left_next      = count_reg;
                have_prev_next = 1'b0;
                offset_next    = cmd_reg.delay;
            end
            dtq_pkg::S_IWALK:
            begin
                // entry under cur is kept in case the walk stops here
                ent_next = data_q;
                if (ins_adv)
                begin
                    offset_next    = offset_reg - data_q.delta;
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                    cur_next       = link_q;
                    left_next      = left_dec;
                    rd_addr        = link_q;
                end
            end
            dtq_pkg::S_ILINK:
            begin
                // new entry points at the stop position, which is prev's old successor
                data_we            = 1'b1;
                data_waddr         = slot_reg;
                data_wdata.payload = cmd_reg.payload;
                data_wdata.tag     = cmd_reg.tag;
                data_wdata.delta   = offset_reg;
                link_we            = 1'b1;
                link_waddr         = slot_reg;
                link_wdata         = cur_reg;
                if (!have_prev_reg)
                begin
                    head_next = slot_reg;
                end
            end
            dtq_pkg::S_IFIX:
            begin
                if (have_prev_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = prev_reg;
                    link_wdata = slot_reg;
                end
                // successor loses the new entry's delta
                if (left_reg != '0)
                begin
                    data_we            = 1'b1;
                    data_waddr         = cur_reg;
                    data_wdata.payload = ent_reg.payload;
                    data_wdata.tag     = ent_reg.tag;
                    data_wdata.delta   = ent_reg.delta - offset_reg;
                end
                count_next = count_reg + CW'(1);
            end
            dtq_pkg::S_PWALK:
            begin
                cur_next  = link_q;
                left_next = left_dec;
                rd_addr   = link_q;
                if (tag_hit)
                begin
                    // unlink and push onto the free chain, delta moves on
                    link_we      = 1'b1;
                    link_waddr   = cur_reg;
                    link_wdata   = free_reg;
                    free_next    = cur_reg;
                    removed_next = removed_reg + CW'(1);
                    carry_next   = eff_delta;
                    run_next     = 1'b1;
                    if (!have_prev_reg)
                    begin
                        head_next = link_q;
                    end
                end
                else
                begin
                    // first survivor after a removed run takes the carried delta
                    if (run_reg)
                    begin
                        data_we            = 1'b1;
                        data_waddr         = cur_reg;
                        data_wdata.payload = data_q.payload;
                        data_wdata.tag     = data_q.tag;
                        data_wdata.delta   = eff_delta;
                    end
                    if (run_reg && have_prev_reg)
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = cur_reg;
                    end
                    carry_next     = '0;
                    run_next       = 1'b0;
                    prev_next      = cur_reg;
                    have_prev_next = 1'b1;
                end
            end
            dtq_pkg::S_PEND:
            begin
                count_next = purge_cnt;
                if (purge_cnt == '0)
                begin
                    head_next = '0;
                end
            end
            dtq_pkg::S_POP:
            begin
                pop_next   = data_q;
                head_next  = link_q;
                link_we    = 1'b1;
                link_waddr = head_reg;
                link_wdata = free_reg;
                free_next  = head_reg;
                count_next = count_reg - CW'(1);
            end
            dtq_pkg::S_RESP:
            begin
                // output register frees as the previous result is taken
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.out_payload = pop_reg.payload;
                    rsp_next.out_tag     = pop_reg.tag;
                    rsp_next.out_delta   = pop_reg.delta;
                    rsp_next.removed     = OW'(removed_reg);
                    rsp_next.occupancy   = OW'(count_reg);
                    rsp_valid_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtq_pkg::S_IDLE;
            head_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and payload registers, loaded before use
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        left_reg      <= left_next;
        offset_reg    <= offset_next;
        carry_reg     <= carry_next;
        run_reg       <= run_next;
        ent_reg       <= ent_next;
        slot_reg      <= slot_next;
        status_reg    <= status_next;
        pop_reg       <= pop_next;
        removed_reg   <= removed_next;
        rsp_reg       <= rsp_next;
    end

    // occupancy never passes the slot count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy above depth");

    // every held entry sits in a slot that was allocated at some point
    a_count_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fresh_reg)
        else $error("occupancy above fill mark");

    // a walk step always has an entry left to visit
    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::S_IWALK || state_reg == dtq_pkg::S_PWALK) |-> (left_reg != '0))
        else $error("walk past end of list");

    // leaving the response state always presents a result
    a_resp_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtq_pkg::S_RESP && state_next == dtq_pkg::S_IDLE) |=> rsp_valid_reg)
        else $error("result item lost");

endmodule

FILE: hdl/dtq_ram.sv
`timescale 1ns / 1ps

module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
